// ===== hw/rtl/tlife_pkg.sv =====
// Shared types and constants for the toroidal life block with cell ages.
// Used by the controller, the datapath and the top level; no dependencies.
package tlife_pkg;

	localparam logic [15:0] AGE_MAX    = 16'hFFFF;
	localparam logic [3:0]  NBR_BIRTH  = 4'd3;
	localparam logic [3:0]  NBR_KEEP   = 4'd2;
	localparam logic [3:0]  K_CENTER   = 4'd4;
	localparam logic [3:0]  K_LAST     = 4'd9;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STEP_DEC,
		STEP_HOLD,
		STEP_INC
	} step_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_CLR,
		ST_GEN,
		ST_COPY,
		ST_COPY_END
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic wr_cell;
		logic rd_cell;
		logic clr_rst;
		logic clr_step;
		logic gen_rst;
		logic gen_step;
		logic copy_step;
		logic emit;
		logic emit_chk;
		logic emit_rd;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic clr_last;
		logic gen_last;
		logic copy_last;
	} stat_t;

	// column offset of neighbor position k (3x3 window, row-major)
	function automatic step_t nbr_dx(input logic [3:0] k);
		case (k)
			4'd0, 4'd3, 4'd6: nbr_dx = STEP_DEC;
			4'd2, 4'd5, 4'd8: nbr_dx = STEP_INC;
			default:          nbr_dx = STEP_HOLD;
		endcase
	endfunction

	// row offset of neighbor position k
	function automatic step_t nbr_dy(input logic [3:0] k);
		case (k)
			4'd0, 4'd1, 4'd2: nbr_dy = STEP_DEC;
			4'd6, 4'd7, 4'd8: nbr_dy = STEP_INC;
			default:          nbr_dy = STEP_HOLD;
		endcase
	endfunction

endpackage

// ===== hw/rtl/toroidal_life_automaton_with_age.sv =====
// Top level of the toroidal life block with cell ages: APB register file,
// controller and datapath. Depends on tlife_pkg, tlife_ctrl, tlife_dp.
//
// Requests enter on start/op/col/row/age_value and are taken when start is
// high and busy is low. Every request gives one result on cell_age and
// rejected, shown for one cycle with done high; the receiver cannot stall.
// A write is done in the EXEC state, a read in EXEC and then RDATA, and
// a clear sweeps all MAX_COLS*MAX_ROWS cells. An advance scans the W by
// H grid in use and reads nine cells per cell through the single read
// port of the age RAM, then copies the new generation back at one cell
// per cycle.
// Requests are taken one at a time; busy is high while one is in work.
// grid_width (address 0) and grid_height (address 4) reset to 64. They
// are to be written over the APB port only while the block is idle, by
// the user; the block does not enforce it. After reset it clears the age
// RAM, one cell per cycle, holding busy high; register writes still work.
module toroidal_life_automaton_with_age
	import tlife_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [15:0] age_value,
	output logic        done,
	output logic [15:0] cell_age,
	output logic        rejected,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] gw_q, gh_q;
	cmd_t       cmd;
	stat_t      stat;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd64;
			gh_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) gh_q <= pwdata[6:0];
			else          gw_q <= pwdata[6:0];
		end
	end

	assign prdata = paddr[2] ? {25'd0, gh_q} : {25'd0, gw_q};
	assign pready = 1'b1;

	tlife_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	tlife_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op        (op),
		.col       (col),
		.row       (row),
		.age_value (age_value),
		.gw        (gw_q),
		.gh        (gh_q),
		.cell_age  (cell_age),
		.rejected  (rejected),
		.done      (done)
	);

endmodule

// ===== hw/rtl/tlife_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tlife_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/tlife_ctrl.sv =====
// Sequencer for the life block: init clear, item execution, clear sweep,
// generation scan and copy-back. Depends on tlife_pkg.
module tlife_ctrl
	import tlife_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (stat.op)
					OP_WRITE:   state_d = ST_IDLE;
					OP_CLEAR:   state_d = ST_CLR;
					OP_ADVANCE: state_d = ST_GEN;
					OP_READ:    state_d = ST_RDATA;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_RDATA:    state_d = ST_IDLE;
			ST_CLR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_GEN: begin
				if (stat.gen_last) state_d = ST_COPY;
			end
			ST_COPY: begin
				if (stat.copy_last) state_d = ST_COPY_END;
			end
			ST_COPY_END: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_INIT: cmd.clr_step = 1'b1;
			ST_IDLE: cmd.load = start;
			ST_EXEC: begin
				case (stat.op)
					OP_WRITE: begin
						cmd.wr_cell  = 1'b1;
						cmd.emit     = 1'b1;
						cmd.emit_chk = 1'b1;
					end
					OP_CLEAR:   cmd.clr_rst = 1'b1;
					OP_ADVANCE: cmd.gen_rst = 1'b1;
					OP_READ:    cmd.rd_cell = 1'b1;
					default:    cmd = '0;
				endcase
			end
			ST_RDATA: begin
				cmd.emit     = 1'b1;
				cmd.emit_chk = 1'b1;
				cmd.emit_rd  = 1'b1;
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				cmd.emit     = stat.clr_last;
			end
			ST_GEN:      cmd.gen_step  = 1'b1;
			ST_COPY:     cmd.copy_step = 1'b1;
			ST_COPY_END: cmd.emit      = 1'b1;
			default:     cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/tlife_dp.sv =====
// Datapath of the life block: item registers, cell scan counters, neighbor
// address wrap, live count, age RAMs and result registers.
// Depends on tlife_pkg and tlife_ram.
module tlife_dp
	import tlife_pkg::*;
#(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [1:0]  op,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [15:0] age_value,
	input  logic [6:0]  gw,
	input  logic [6:0]  gh,
	output logic [15:0] cell_age,
	output logic        rejected,
	output logic        done
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int SWC   = $clog2(MAX_COLS + 1);
	localparam int SWR   = $clog2(MAX_ROWS + 1);
	localparam int SW0   = (SWC > SWR) ? SWC : SWR;
	localparam int SW    = (SW0 > 7) ? SW0 : 7;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] y,
		input logic [CW-1:0] x);
		cell_addr = AW'(y) * AW'(MAX_COLS) + AW'(x);
	endfunction

	op_t            op_q;
	logic [7:0]     col_q, row_q;
	logic [15:0]    age_q;
	logic [CW-1:0]  x_q, nx;
	logic [RW-1:0]  y_q, ny;
	logic [3:0]     k_q, cnt_q, nbr_n;
	logic [15:0]    cur_q, nxt_age;
	logic [AW-1:0]  a_q;
	logic           rdv_s1;
	logic [3:0]     rdk_s1;
	logic           cp_wr_s1;
	logic [AW-1:0]  cp_addr_s1;
	logic           done_q, rej_q;
	logic [15:0]    cell_q;

	logic [SW-1:0]  w_eff, h_eff, wm1, hm1, col_ext, row_ext;
	logic           in_grid, x_last, y_last, scan_rd, gen_wr, item_wr;
	logic [AW-1:0]  item_addr, nbr_addr, here_addr;
	logic [15:0]    age_rd, next_rd;
	logic           age_we, age_re;
	logic [AW-1:0]  age_waddr, age_raddr;
	logic [15:0]    age_wdata;

	// effective grid size: 0 acts as 1, oversize acts as the maximum
	always_comb begin
		if (gw == 7'd0)                   w_eff = SW'(1);
		else if (SW'(gw) > SW'(MAX_COLS)) w_eff = SW'(MAX_COLS);
		else                              w_eff = SW'(gw);
		if (gh == 7'd0)                   h_eff = SW'(1);
		else if (SW'(gh) > SW'(MAX_ROWS)) h_eff = SW'(MAX_ROWS);
		else                              h_eff = SW'(gh);
	end
	assign wm1 = w_eff - SW'(1);
	assign hm1 = h_eff - SW'(1);

	// item coordinate check and address
	assign col_ext   = SW'(col_q[6:0]);
	assign row_ext   = SW'(row_q[6:0]);
	assign in_grid   = !col_q[7] && !row_q[7] && (col_ext < w_eff) && (row_ext < h_eff);
	assign item_addr = cell_addr(row_ext[RW-1:0], col_ext[CW-1:0]);

	// neighbor position with toroidal wrap
	always_comb begin
		case (nbr_dx(k_q))
			STEP_DEC: nx = (x_q == '0) ? wm1[CW-1:0] : CW'(x_q - 1'b1);
			STEP_INC: nx = ((SW'(x_q) + SW'(1)) >= w_eff) ? '0 : CW'(x_q + 1'b1);
			default:  nx = x_q;
		endcase
		case (nbr_dy(k_q))
			STEP_DEC: ny = (y_q == '0) ? hm1[RW-1:0] : RW'(y_q - 1'b1);
			STEP_INC: ny = ((SW'(y_q) + SW'(1)) >= h_eff) ? '0 : RW'(y_q + 1'b1);
			default:  ny = y_q;
		endcase
	end
	assign nbr_addr  = cell_addr(ny, nx);
	assign here_addr = cell_addr(y_q, x_q);

	assign x_last  = (SW'(x_q) == wm1);
	assign y_last  = (SW'(y_q) == hm1);
	assign scan_rd = cmd.gen_step && (k_q != K_LAST);
	assign gen_wr  = cmd.gen_step && (k_q == K_LAST);
	assign item_wr = cmd.wr_cell && in_grid;

	// B3/S23 with age; last neighbor sample arrives in the write cycle
	always_comb begin
		nbr_n = cnt_q + ((age_rd != 16'd0) ? 4'd1 : 4'd0);
		if (cur_q == 16'd0) begin
			nxt_age = (nbr_n == NBR_BIRTH) ? 16'd1 : 16'd0;
		end else if (nbr_n == NBR_KEEP || nbr_n == NBR_BIRTH) begin
			nxt_age = (cur_q == AGE_MAX) ? AGE_MAX : cur_q + 16'd1;
		end else begin
			nxt_age = 16'd0;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			col_q <= col;
			row_q <= row;
			age_q <= age_value;
		end
	end

	// scan counters, live count and copy pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			a_q      <= '0;
			rdv_s1   <= 1'b0;
			cp_wr_s1 <= 1'b0;
		end else begin
			rdv_s1   <= scan_rd;
			cp_wr_s1 <= cmd.copy_step;
			if (cmd.clr_rst) a_q <= '0;
			else if (cmd.clr_step) a_q <= a_q + 1'b1;
			if (rdv_s1 && rdk_s1 != K_CENTER && age_rd != 16'd0) cnt_q <= cnt_q + 4'd1;
			if (cmd.gen_rst) begin
				x_q   <= '0;
				y_q   <= '0;
				k_q   <= '0;
				cnt_q <= '0;
			end else if (scan_rd) begin
				k_q <= k_q + 4'd1;
			end else if (gen_wr || cmd.copy_step) begin
				k_q   <= '0;
				cnt_q <= '0;
				if (x_last) begin
					x_q <= '0;
					y_q <= y_last ? '0 : RW'(y_q + 1'b1);
				end else begin
					x_q <= CW'(x_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rdk_s1     <= k_q;
		cp_addr_s1 <= here_addr;
		if (rdv_s1 && rdk_s1 == K_CENTER) cur_q <= age_rd;
	end

	// age RAM port muxing
	assign age_we    = item_wr || cmd.clr_step || cp_wr_s1;
	assign age_waddr = cmd.clr_step ? a_q : (cp_wr_s1 ? cp_addr_s1 : item_addr);
	assign age_wdata = cmd.clr_step ? 16'd0 : (cp_wr_s1 ? next_rd : age_q);
	assign age_re    = cmd.rd_cell || scan_rd;
	assign age_raddr = cmd.rd_cell ? item_addr : nbr_addr;

	tlife_ram #(.WIDTH(16), .DEPTH(CELLS)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (age_waddr),
		.wdata (age_wdata),
		.re    (age_re),
		.raddr (age_raddr),
		.rdata (age_rd)
	);

	tlife_ram #(.WIDTH(16), .DEPTH(CELLS)) u_next_ram (
		.clk   (clk),
		.we    (gen_wr),
		.waddr (here_addr),
		.wdata (nxt_age),
		.re    (cmd.copy_step),
		.raddr (here_addr),
		.rdata (next_rd)
	);

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rej_q  <= cmd.emit_chk && !in_grid;
			cell_q <= (cmd.emit_rd && in_grid) ? age_rd : 16'd0;
		end
	end

	assign stat.op        = op_q;
	assign stat.clr_last  = (a_q == AW'(CELLS - 1));
	assign stat.gen_last  = gen_wr && x_last && y_last;
	assign stat.copy_last = x_last && y_last;

	assign done     = done_q;
	assign rejected = rej_q;
	assign cell_age = cell_q;

	// the result strobe is a single-cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held");

	// only one source writes the age RAM in a cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({item_wr, cmd.clr_step, cp_wr_s1})) else $error("age RAM write clash");

	// neighbor index stays within the window plus the write slot
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= K_LAST) else $error("neighbor index out of range");

endmodule

// ===== tb/tb_toroidal_life_automaton_with_age.sv =====
// Testbench for the toroidal life block with cell ages: directed table, then random phases
// over several grid sizes, results checked against typed values or a cycle-free predictor.
// Depends on tlife_pkg and toroidal_life_automaton_with_age.
`timescale 1ns / 1ps

module tb_toroidal_life_automaton_with_age;
	import tlife_pkg::*;

	localparam int COLS = 64;
	localparam int ROWS = 64;
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [15:0] age;
		logic        rej;
	} cell_result_t;

	typedef struct {
		op_t         op;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [15:0] age;
		bit          typed;
		logic [15:0] exp_age;
		logic        exp_rej;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [7:0]  col;
	logic [7:0]  row;
	logic [15:0] age_value;
	logic        done;
	logic [15:0] cell_age;
	logic        rejected;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	toroidal_life_automaton_with_age #(
		.MAX_COLS(COLS),
		.MAX_ROWS(ROWS)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .col(col),
		.row(row), .age_value(age_value), .done(done), .cell_age(cell_age),
		.rejected(rejected), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predicted state
	logic [15:0] life_grid [0:COLS*ROWS-1];
	logic [15:0] life_next [0:COLS*ROWS-1];
	logic [6:0]  width_reg;
	logic [6:0]  height_reg;
	cell_result_t pending_results[$];

	int error_count = 0;
	int request_count = 0;
	int result_count = 0;
	int advance_count = 0;
	int reject_count = 0;
	int idle_cycles = 0;
	bit no_idle = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_size(logic [6:0] v, int limit);
		if (v == 0) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	function automatic int wrap_pos(int p, int d, int n);
		if (d < 0) return (p == 0) ? n - 1 : p - 1;
		if (d > 0) return (p + 1 >= n) ? 0 : p + 1;
		return p;
	endfunction

	// one generation of B3/S23 over the grid in use
	function automatic void step_generation();
		int w;
		int h;
		int n;
		int a;
		w = eff_size(width_reg, COLS);
		h = eff_size(height_reg, ROWS);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (!(dx == 0 && dy == 0) &&
								life_grid[wrap_pos(y, dy, h)*COLS + wrap_pos(x, dx, w)] != 0)
							n++;
				a = y*COLS + x;
				if (life_grid[a] == 0)
					life_next[a] = (n == 3) ? 16'd1 : 16'd0;
				else if (n == 2 || n == 3)
					life_next[a] = (life_grid[a] == AGE_MAX) ? AGE_MAX : life_grid[a] + 16'd1;
				else
					life_next[a] = 16'd0;
			end
		end
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				life_grid[y*COLS + x] = life_next[y*COLS + x];
	endfunction

	// apply one request to the predicted grid and return its result
	function automatic cell_result_t predict_cell(op_t o, logic [7:0] c, logic [7:0] r,
			logic [15:0] a);
		cell_result_t res;
		int sc;
		int sr;
		res.age = 16'd0;
		res.rej = 1'b0;
		sc = $signed(c);
		sr = $signed(r);
		case (o)
			OP_CLEAR: begin
				foreach (life_grid[i]) life_grid[i] = 16'd0;
			end
			OP_ADVANCE: begin
				step_generation();
			end
			default: begin
				if (sc < 0 || sr < 0 || sc >= eff_size(width_reg, COLS) ||
						sr >= eff_size(height_reg, ROWS))
					res.rej = 1'b1;
				else if (o == OP_WRITE)
					life_grid[sr*COLS + sc] = a;
				else
					res.age = life_grid[sr*COLS + sc];
			end
		endcase
		return res;
	endfunction

	// drive one request and hold it until the block takes it
	task automatic issue_request(op_t o, logic [7:0] c, logic [7:0] r, logic [15:0] a,
			bit typed, logic [15:0] t_age, logic t_rej);
		int gap;
		cell_result_t res;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		col <= c;
		row <= r;
		age_value <= a;
		do @(posedge clk); while (busy);
		res = predict_cell(o, c, r, a);
		if (typed) begin
			res.age = t_age;
			res.rej = t_rej;
		end
		pending_results.push_back(res);
		request_count++;
		if (o == OP_ADVANCE) advance_count++;
		if (res.rej) reject_count++;
	endtask

	// let every outstanding request finish
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [6:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= {25'($urandom_range(0, 32'h1FFFFFF)), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no request or result for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
		if (done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result age=%0d rej=%0b", cell_age, rejected);
			end else begin
				want = pending_results.pop_front();
				if (cell_age !== want.age || rejected !== want.rej) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch at result %0d: want age=%0d rej=%0b got age=%0d rej=%0b",
							result_count, want.age, want.rej, cell_age, rejected);
				end
			end
		end
	end

	stim_row_t directed [] = '{
		'{OP_READ,    8'd0,   8'd0,   16'd0,     1, 16'd0,     1'b0},
		'{OP_READ,    8'd63,  8'd63,  16'd0,     1, 16'd0,     1'b0},
		'{OP_WRITE,   8'h80,  8'd0,   16'hFFFF,  1, 16'd0,     1'b1},
		'{OP_WRITE,   8'd0,   8'h7F,  16'h1234,  1, 16'd0,     1'b1},
		'{OP_READ,    8'd64,  8'd0,   16'd0,     1, 16'd0,     1'b1},
		'{OP_READ,    8'd0,   8'hFF,  16'd0,     1, 16'd0,     1'b1},
		'{OP_WRITE,   8'd0,   8'd0,   16'hFFFF,  1, 16'd0,     1'b0},
		'{OP_READ,    8'd0,   8'd0,   16'd0,     1, 16'hFFFF,  1'b0},
		'{OP_WRITE,   8'd63,  8'd63,  16'd1,     1, 16'd0,     1'b0},
		'{OP_READ,    8'd63,  8'd63,  16'd0,     1, 16'd1,     1'b0},
		'{OP_CLEAR,   8'd0,   8'd0,   16'd0,     1, 16'd0,     1'b0},
		'{OP_READ,    8'd0,   8'd0,   16'd0,     1, 16'd0,     1'b0},
		// blinker across the horizontal wrap, plus a block with a saturated cell
		'{OP_WRITE,   8'd63,  8'd5,   16'd7,     0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd0,   8'd5,   16'd1,     0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd1,   8'd5,   16'd1,     0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd10,  8'd10,  16'hFFFF,  0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd11,  8'd10,  16'd3,     0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd10,  8'd11,  16'd3,     0, 16'd0,     1'b0},
		'{OP_WRITE,   8'd11,  8'd11,  16'd3,     0, 16'd0,     1'b0},
		'{OP_ADVANCE, 8'd0,   8'd0,   16'd0,     1, 16'd0,     1'b0},
		'{OP_READ,    8'd0,   8'd5,   16'd0,     0, 16'd0,     1'b0},
		'{OP_READ,    8'd0,   8'd4,   16'd0,     0, 16'd0,     1'b0},
		'{OP_READ,    8'd63,  8'd5,   16'd0,     0, 16'd0,     1'b0},
		'{OP_READ,    8'd10,  8'd10,  16'd0,     0, 16'd0,     1'b0}
	};

	// grid sizes per random phase: register values, clamped ones included
	logic [6:0] phase_w [] = '{7'd8, 7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd3, 7'd16, 7'd64, 7'd6};
	logic [6:0] phase_h [] = '{7'd8, 7'd1, 7'd3, 7'd5, 7'd2, 7'd127, 7'd3, 7'd16, 7'd64, 7'd1};

	initial begin
		int w;
		int h;
		int pick;
		op_t o;
		logic [7:0] c;
		logic [7:0] r;
		logic [15:0] a;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_WRITE;
		col <= 8'd0;
		row <= 8'd0;
		age_value <= 16'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'd0;
		width_reg = 7'd64;
		height_reg = 7'd64;
		foreach (life_grid[i]) life_grid[i] = 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			issue_request(directed[i].op, directed[i].col, directed[i].row, directed[i].age,
				directed[i].typed, directed[i].exp_age, directed[i].exp_rej);

		// random phases, one grid size each
		foreach (phase_w[p]) begin
			wait_idle();
			apb_write(ADDR_WIDTH, phase_w[p]);
			apb_write(ADDR_HEIGHT, phase_h[p]);
			w = eff_size(width_reg, COLS);
			h = eff_size(height_reg, ROWS);
			no_idle = (p % 3 == 2);
			for (int k = 0; k < 12; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) o = OP_WRITE;
				else if (pick < 75) o = OP_READ;
				else if (pick < 78) o = OP_CLEAR;
				else o = (w*h <= 1024) ? OP_ADVANCE : OP_READ;
				if ($urandom_range(0, 9) < 8) begin
					c = 8'($urandom_range(0, w - 1));
					r = 8'($urandom_range(0, h - 1));
				end else begin
					c = 8'($urandom_range(0, 255));
					r = 8'($urandom_range(0, 255));
				end
				case ($urandom_range(0, 5))
					0: a = 16'd0;
					1: a = 16'hFFFF;
					2: a = 16'hFFFE;
					default: a = 16'($urandom_range(1, 65535));
				endcase
				issue_request(o, c, r, a, 0, 16'd0, 1'b0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d advances, %0d rejected) over %0d grid sizes",
			request_count, advance_count, reject_count, phase_w.size() + 1);
		$display("results seen %0d, mismatches %0d", result_count, error_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
